// ----- rtl/core/stz_pkg.sv -----
// ----------------------------------------------------------------------------
// stz_pkg
// Shared types, token codes and keyword tables of the source tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package stz_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int LINE_BITS_DEF     = 16;
    localparam int MIDQ_DEPTH        = 2;
    localparam int OUTQ_DEPTH        = 4;
    localparam int KW_COUNT          = 8;
    localparam int KW_MAX_LEN        = 5;

    localparam logic [4:0] KIND_INT    = 5'd0;
    localparam logic [4:0] KIND_IDENT  = 5'd1;
    localparam logic [4:0] KIND_LET    = 5'd2;
    localparam logic [4:0] KIND_PLUS   = 5'd10;
    localparam logic [4:0] KIND_MINUS  = 5'd11;
    localparam logic [4:0] KIND_STAR   = 5'd12;
    localparam logic [4:0] KIND_SLASH  = 5'd13;
    localparam logic [4:0] KIND_LESS   = 5'd14;
    localparam logic [4:0] KIND_LPAREN = 5'd15;
    localparam logic [4:0] KIND_RPAREN = 5'd16;
    localparam logic [4:0] KIND_LBRACE = 5'd17;
    localparam logic [4:0] KIND_RBRACE = 5'd18;
    localparam logic [4:0] KIND_SEMI   = 5'd19;
    localparam logic [4:0] KIND_ASSIGN = 5'd20;
    localparam logic [4:0] KIND_EQEQ   = 5'd21;
    localparam logic [4:0] KIND_EOF    = 5'd22;
    localparam logic [4:0] KIND_ERROR  = 5'd23;

    // keyword text, first character in the top byte
    localparam logic [39:0] KW_TEXT [KW_COUNT] = '{
        {"let", 16'h0}, "print", "input", {"if", 24'h0},
        {"else", 8'h0}, "while", {"true", 8'h0}, "false"
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd5, 3'd5, 3'd2, 3'd4, 3'd5, 3'd4, 3'd5
    };

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_source;
    } src_item_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [15:0] token_line;
        logic        last_of_run;
    } token_t;

    // classified byte handed from front to back
    typedef struct packed {
        logic       eos;
        logic [7:0] ch;
        logic       blank;
        logic       newline;
        logic       digit;
        logic       alpha;
        logic       slash;
        logic       equal;
        logic       op;
        logic       bad;
        logic [4:0] op_kind;
    } cls_t;

    // scanner to output queue write group
    typedef struct packed {
        logic [1:0] count;
        token_t     t0;
        token_t     t1;
    } tok_wr_t;

    function automatic logic [7:0] kw_char(input logic [2:0] idx, input logic [2:0] k);
        logic [39:0] txt;
        logic [2:0]  kc;
        txt = KW_TEXT[idx];
        kc  = (k < 3'(KW_MAX_LEN)) ? k : 3'd0;
        return txt[8*(4-kc) +: 8];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/stz_fifo.sv -----
// ----------------------------------------------------------------------------
// stz_fifo
// Small register queue, one write and one read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stz_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  valid
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign valid   = (cnt_reg != '0);
    assign rd_data = mem_reg[rp_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && valid;

    always_comb
    begin
        wp_next  = do_wr ? ptr_inc(wp_reg) : wp_reg;
        rp_next  = do_rd ? ptr_inc(rp_reg) : rp_reg;
        cnt_next = cnt_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule

`default_nettype wire

// ----- rtl/core/stz_front.sv -----
// ----------------------------------------------------------------------------
// stz_front
// Byte classifier: sorts each source byte into the scanner's classes.
// ----------------------------------------------------------------------------
`default_nettype none

module stz_front (
    input  wire stz_pkg::src_item_t item,
    output stz_pkg::cls_t           cls
);
    import stz_pkg::*;

    logic [7:0] c;

    assign c = item.char_code;

    always_comb
    begin
        cls         = '0;
        cls.eos     = item.end_of_source;
        cls.ch      = c;
        cls.newline = (c == 8'h0A);
        cls.blank   = (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
        cls.digit   = (c >= "0") && (c <= "9");
        cls.alpha   = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"))
                      || (c == "_");
        cls.slash   = (c == "/");
        cls.equal   = (c == "=");
        cls.op      = 1'b1;
        unique case (c)
            "+":     cls.op_kind = KIND_PLUS;
            "-":     cls.op_kind = KIND_MINUS;
            "*":     cls.op_kind = KIND_STAR;
            "<":     cls.op_kind = KIND_LESS;
            "(":     cls.op_kind = KIND_LPAREN;
            ")":     cls.op_kind = KIND_RPAREN;
            "{":     cls.op_kind = KIND_LBRACE;
            "}":     cls.op_kind = KIND_RBRACE;
            ";":     cls.op_kind = KIND_SEMI;
            default:
            begin
                cls.op      = 1'b0;
                cls.op_kind = KIND_ERROR;
            end
        endcase
        cls.bad = !(cls.blank || cls.digit || cls.alpha || cls.slash
                    || cls.equal || cls.op);
    end

endmodule

`default_nettype wire

// ----- rtl/core/stz_back.sv -----
// ----------------------------------------------------------------------------
// stz_back
// Scanner: mode machine, counters and keyword mask; emits up to two tokens
// per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module stz_back #(
    parameter int POSITION_BITS = stz_pkg::POSITION_BITS_DEF,
    parameter int LINE_BITS     = stz_pkg::LINE_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire stz_pkg::cls_t    item,
    input  wire logic             item_valid,
    output logic                  item_pop,
    input  wire logic             room,
    output stz_pkg::tok_wr_t      wr
);
    import stz_pkg::*;

    typedef enum logic [6:0] {
        MODE_IDLE    = 7'b0000001,
        MODE_NUMBER  = 7'b0000010,
        MODE_WORD    = 7'b0000100,
        MODE_SLASH   = 7'b0001000,
        MODE_EQUAL   = 7'b0010000,
        MODE_COMMENT = 7'b0100000,
        MODE_HALT    = 7'b1000000
    } mode_t;

    localparam logic [POSITION_BITS-1:0] POS_MAX  = '1;
    localparam logic [LINE_BITS-1:0]     LINE_MAX = '1;

    mode_t                    mode_reg, mode_next, idle_mode;
    logic [POSITION_BITS-1:0] pos_reg, pos_next, pstart_reg, pstart_next;
    logic [POSITION_BITS-1:0] pos_inc, pend_len, idle_pos;
    logic [LINE_BITS-1:0]     line_reg, line_next, pline_reg, pline_next;
    logic [LINE_BITS-1:0]     line_inc, idle_line;
    logic [7:0]               cand_reg, cand_next, idle_cand, grow_cand;
    logic [4:0]               word_kind;
    logic                     fire, use_idle, do_flush, eq_tok, eof;
    logic                     flush_valid, sec_valid, idle_emit, idle_begin;
    token_t                   flush_tok, sec_tok, idle_tok;

    function automatic logic [7:0] narrow(input logic [7:0] mask,
                                          input logic [2:0] k,
                                          input logic [7:0] c);
        logic [7:0] keep;
        keep = '0;
        for (int i = 0; i < KW_COUNT; i++)
            keep[i] = mask[i] && (k < KW_LEN[i]) && (c == kw_char(3'(i), k));
        return keep;
    endfunction

    assign fire     = item_valid && room;
    assign item_pop = fire;
    assign pos_inc  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
    assign line_inc = (line_reg == LINE_MAX) ? line_reg : line_reg + 1'b1;
    assign pend_len = pos_reg - pstart_reg;

    // first keyword whose length matches wins
    always_comb
    begin
        word_kind = KIND_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--)
            if (cand_reg[i] && (pend_len == POSITION_BITS'(KW_LEN[i])))
                word_kind = KIND_LET + 5'(i);
    end

    always_comb
    begin
        if ((pos_reg == POS_MAX) || (pend_len >= POSITION_BITS'(KW_MAX_LEN)))
            grow_cand = '0;
        else
            grow_cand = narrow(cand_reg, pend_len[2:0], item.ch);
    end

    // scan of a byte from the idle mode
    always_comb
    begin
        idle_tok.token_kind   = item.op ? item.op_kind : KIND_ERROR;
        idle_tok.token_start  = 16'(pos_reg);
        idle_tok.token_length = 16'd1;
        idle_tok.token_line   = 16'(line_reg);
        idle_tok.last_of_run  = 1'b1;
        idle_emit  = item.op || item.bad;
        idle_begin = item.digit || item.alpha || item.slash || item.equal;
        idle_pos   = item.bad ? pos_reg : pos_inc;
        idle_line  = item.newline ? line_inc : line_reg;
        idle_cand  = item.alpha ? narrow(8'hFF, 3'd0, item.ch) : 8'h00;
        if (item.bad)
            idle_mode = MODE_HALT;
        else if (item.digit)
            idle_mode = MODE_NUMBER;
        else if (item.alpha)
            idle_mode = MODE_WORD;
        else if (item.slash)
            idle_mode = MODE_SLASH;
        else if (item.equal)
            idle_mode = MODE_EQUAL;
        else
            idle_mode = MODE_IDLE;
    end

    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        line_next   = line_reg;
        pstart_next = pstart_reg;
        pline_next  = pline_reg;
        cand_next   = cand_reg;
        use_idle    = 1'b0;
        do_flush    = 1'b0;
        eq_tok      = 1'b0;
        eof         = 1'b0;
        if (item.eos)
        begin
            do_flush    = 1'b1;
            eof         = 1'b1;
            mode_next   = MODE_IDLE;
            pos_next    = '0;
            line_next   = LINE_BITS'(1);
            pstart_next = '0;
            pline_next  = LINE_BITS'(1);
            cand_next   = '0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_NUMBER:
                begin
                    if (item.digit)
                        pos_next = pos_inc;
                    else
                    begin
                        do_flush = 1'b1;
                        use_idle = 1'b1;
                    end
                end
                MODE_WORD:
                begin
                    if (item.alpha || item.digit)
                    begin
                        cand_next = grow_cand;
                        pos_next  = pos_inc;
                    end
                    else
                    begin
                        do_flush = 1'b1;
                        use_idle = 1'b1;
                    end
                end
                MODE_SLASH:
                begin
                    if (item.slash)
                    begin
                        mode_next = MODE_COMMENT;
                        pos_next  = pos_inc;
                    end
                    else
                    begin
                        do_flush = 1'b1;
                        use_idle = 1'b1;
                    end
                end
                MODE_EQUAL:
                begin
                    if (item.equal)
                    begin
                        pos_next  = pos_inc;
                        eq_tok    = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        do_flush = 1'b1;
                        use_idle = 1'b1;
                    end
                end
                MODE_COMMENT:
                begin
                    if (item.newline)
                        use_idle = 1'b1;
                    else
                        pos_next = pos_inc;
                end
                MODE_HALT:
                begin
                end
                MODE_IDLE:
                    use_idle = 1'b1;
                default:
                    use_idle = 1'b1;
            endcase
            if (use_idle)
            begin
                mode_next = idle_mode;
                pos_next  = idle_pos;
                line_next = idle_line;
                cand_next = idle_cand;
                if (idle_begin)
                begin
                    pstart_next = pos_reg;
                    pline_next  = line_reg;
                end
            end
        end
    end

    // token pair: pending token first, then EOF, '==' or the idle token
    always_comb
    begin
        flush_valid = do_flush && ((mode_reg == MODE_NUMBER) || (mode_reg == MODE_WORD)
                      || (mode_reg == MODE_SLASH) || (mode_reg == MODE_EQUAL));
        flush_tok.token_start  = 16'(pstart_reg);
        flush_tok.token_length = 16'(pend_len);
        flush_tok.token_line   = 16'(pline_reg);
        flush_tok.last_of_run  = 1'b0;
        if (mode_reg == MODE_NUMBER)
            flush_tok.token_kind = KIND_INT;
        else if (mode_reg == MODE_WORD)
            flush_tok.token_kind = word_kind;
        else if (mode_reg == MODE_SLASH)
            flush_tok.token_kind = KIND_SLASH;
        else
            flush_tok.token_kind = KIND_ASSIGN;

        sec_valid = eof || eq_tok || (use_idle && idle_emit);
        if (eof)
        begin
            sec_tok.token_kind   = KIND_EOF;
            sec_tok.token_start  = 16'(pos_reg);
            sec_tok.token_length = 16'd0;
            sec_tok.token_line   = 16'(line_reg);
            sec_tok.last_of_run  = 1'b1;
        end
        else if (eq_tok)
        begin
            sec_tok.token_kind   = KIND_EQEQ;
            sec_tok.token_start  = 16'(pstart_reg);
            sec_tok.token_length = 16'(pos_inc - pstart_reg);
            sec_tok.token_line   = 16'(pline_reg);
            sec_tok.last_of_run  = 1'b1;
        end
        else
            sec_tok = idle_tok;

        wr.t1 = sec_tok;
        if (flush_valid)
        begin
            wr.t0             = flush_tok;
            wr.t0.last_of_run = !sec_valid;
        end
        else
            wr.t0 = sec_tok;
        wr.count = fire ? (2'(flush_valid) + 2'(sec_valid)) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            line_reg   <= LINE_BITS'(1);
            pstart_reg <= '0;
            pline_reg  <= LINE_BITS'(1);
            cand_reg   <= '0;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            line_reg   <= line_next;
            pstart_reg <= pstart_next;
            pline_reg  <= pline_next;
            cand_reg   <= cand_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/stz_outq.sv -----
// ----------------------------------------------------------------------------
// stz_outq
// Token queue: takes up to two tokens per cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module stz_outq #(
    parameter int DEPTH = stz_pkg::OUTQ_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire stz_pkg::tok_wr_t  wr,
    output logic                   room,
    output stz_pkg::token_t        token,
    output logic                   empty,
    input  wire logic              pop
);
    import stz_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    token_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wp_reg, wp_next, wp_1, rp_reg, rp_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_rd;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign empty = (cnt_reg == '0);
    assign token = mem_reg[rp_reg];
    assign room  = (cnt_reg <= CNT_W'(DEPTH - 2));
    assign do_rd = pop && !empty;
    assign wp_1  = ptr_inc(wp_reg);

    always_comb
    begin
        unique case (wr.count)
            2'd1:    wp_next = wp_1;
            2'd2:    wp_next = ptr_inc(wp_1);
            default: wp_next = wp_reg;
        endcase
        rp_next  = do_rd ? ptr_inc(rp_reg) : rp_reg;
        cnt_next = cnt_reg + CNT_W'(wr.count) - CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.count != 2'd0)
            mem_reg[wp_reg] <= wr.t0;
        if (wr.count == 2'd2)
            mem_reg[wp_1] <= wr.t1;
    end

endmodule

`default_nettype wire

// ----- rtl/core/source_tokenizer.sv -----
// ----------------------------------------------------------------------------
// source_tokenizer
// Streaming lexer: one source byte in, tokens with kind, offset, length and
// line out.
// ----------------------------------------------------------------------------
//  channel   direction  handshake      payload
//  source    in         push / full    src_item (char_code, end_of_source)
//  tokens    out        pop / empty    token (kind, start, length, line, last)
//
//  One byte per cycle while the token queue has room; a byte that yields two
//  tokens is one scanner transfer; both go into the token queue at once.
//  Classified bytes wait in a 2-entry queue; the scanner takes one when the
//  4-entry token queue has two free slots, so a slow token reader stalls it.
//  Tokens are registered in the token queue before they appear on the output.
//  Reset needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module source_tokenizer #(
    parameter int POSITION_BITS = stz_pkg::POSITION_BITS_DEF,
    parameter int LINE_BITS     = stz_pkg::LINE_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire stz_pkg::src_item_t src_item,
    output logic                    empty,
    input  wire logic               pop,
    output stz_pkg::token_t         token
);
    import stz_pkg::*;

    cls_t    front_cls, mid_item;
    logic    mid_valid, mid_pop, room;
    tok_wr_t wr;

    stz_front u_front (
        .item (src_item),
        .cls  (front_cls)
    );

    stz_fifo #(
        .WIDTH ($bits(cls_t)),
        .DEPTH (MIDQ_DEPTH)
    ) u_midq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_cls),
        .full    (full),
        .rd_en   (mid_pop),
        .rd_data (mid_item),
        .valid   (mid_valid)
    );

    stz_back #(
        .POSITION_BITS (POSITION_BITS),
        .LINE_BITS     (LINE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (mid_item),
        .item_valid (mid_valid),
        .item_pop   (mid_pop),
        .room       (room),
        .wr         (wr)
    );

    stz_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .room  (room),
        .token (token),
        .empty (empty),
        .pop   (pop)
    );

`ifndef SYNTH
    // tokens only come from a byte the scanner actually took
    a_wr_needs_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.count != 2'd0) |-> mid_pop)
        else $error("token write without a scanned byte");

    // scanner never takes a byte unless both tokens would fit
    a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        mid_pop |-> room)
        else $error("scanner ran without queue room");

    // end of source always yields at least the EOF token
    a_eos_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_pop && mid_item.eos) |-> (wr.count != 2'd0))
        else $error("end of source produced no token");

    // a written token is visible on the next cycle
    a_wr_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.count != 2'd0) |=> !empty)
        else $error("token queue empty after a write");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for source_tokenizer: drives bytes and end-of-source
// marks through the push/full side, predicts every token in a behavioral
// lexer and checks each popped token field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stz_pkg::*;

    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 24;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

    localparam string LETTERS     = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    localparam string KEY_LETTERS = "letprinufaswhd";
    localparam string DIGITS      = "0123456789";
    localparam string BLANKS      = " \t\r\n";
    localparam string OPS         = "+-*<(){};";

    typedef enum logic [2:0] {
        LX_IDLE, LX_NUMBER, LX_WORD, LX_SLASH, LX_EQUAL, LX_COMMENT, LX_HALT
    } lex_mode_t;

    logic      clk;
    logic      rst_n    = 1'b0;
    logic      push     = 1'b0;
    logic      pop      = 1'b0;
    src_item_t src_item = '0;
    logic      full;
    logic      empty;
    token_t    token;

    source_tokenizer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .src_item (src_item),
        .empty    (empty),
        .pop      (pop),
        .token    (token)
    );

    // lexer state mirrored by the predictor
    lex_mode_t   lex_mode  = LX_IDLE;
    logic [15:0] lex_pos   = '0;
    logic [15:0] lex_line  = 16'd1;
    logic [15:0] tok_start = '0;
    logic [15:0] tok_line  = 16'd1;
    logic [7:0]  kw_live   = '0;

    string  kw_words [8] = '{"let", "print", "input", "if", "else", "while", "true", "false"};
    token_t step_tokens[$];
    token_t expected_tokens[$];

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   items_counted  = 0;
    int   mismatches     = 0;
    int   cycle_count    = 0;
    logic receiver_held  = 1'b0;
    event hold_go;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void queue_token(input logic [4:0] kind, input logic [15:0] start,
                                        input logic [15:0] len, input logic [15:0] line);
        token_t t;
        t = '{token_kind: kind, token_start: start, token_length: len,
              token_line: line, last_of_run: 1'b0};
        if (step_tokens.size() < 2)
            step_tokens = {step_tokens, t};
    endfunction

    function automatic void advance_pos();
        if (lex_pos != COUNT_MAX)
            lex_pos = lex_pos + 16'd1;
    endfunction

    function automatic void advance_line();
        if (lex_line != COUNT_MAX)
            lex_line = lex_line + 16'd1;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == " " || c == "\t" || c == "\r" || c == "\n";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic int single_op_kind(input logic [7:0] c);
        case (c)
            "+":     return KIND_PLUS;
            "-":     return KIND_MINUS;
            "*":     return KIND_STAR;
            "<":     return KIND_LESS;
            "(":     return KIND_LPAREN;
            ")":     return KIND_RPAREN;
            "{":     return KIND_LBRACE;
            "}":     return KIND_RBRACE;
            ";":     return KIND_SEMI;
            default: return -1;
        endcase
    endfunction

    function automatic logic is_unexpected(input logic [7:0] c);
        return !(is_blank(c) || is_digit(c) || is_alpha(c) || c == "/" || c == "=" ||
                 single_op_kind(c) >= 0);
    endfunction

    // keep keywords whose k-th character matches c
    function automatic logic [7:0] narrow_keywords(input logic [7:0] mask, input int k,
                                                   input logic [7:0] c);
        logic [7:0] keep;
        keep = '0;
        for (int i = 0; i < 8; i++)
            if (mask[i] && k < kw_words[i].len() && kw_words[i][k] == c)
                keep[i] = 1'b1;
        return keep;
    endfunction

    function automatic void start_token(input lex_mode_t mode);
        tok_start = lex_pos;
        tok_line  = lex_line;
        lex_mode  = mode;
    endfunction

    function automatic void flush_token();
        logic [15:0] len;
        logic [4:0]  kind;
        len = lex_pos - tok_start;
        case (lex_mode)
            LX_NUMBER: queue_token(KIND_INT, tok_start, len, tok_line);
            LX_WORD:
            begin
                kind = KIND_IDENT;
                // lowest matching keyword wins
                for (int i = 7; i >= 0; i--)
                    if (kw_live[i] && kw_words[i].len() == len)
                        kind = KIND_LET + 5'(i);
                queue_token(kind, tok_start, len, tok_line);
            end
            LX_SLASH:  queue_token(KIND_SLASH, tok_start, len, tok_line);
            LX_EQUAL:  queue_token(KIND_ASSIGN, tok_start, len, tok_line);
            default:   ;
        endcase
        if (lex_mode != LX_HALT)
            lex_mode = LX_IDLE;
        kw_live = '0;
    endfunction

    function automatic void scan_from_idle(input logic [7:0] c);
        int op;
        op = single_op_kind(c);
        if (is_blank(c))
        begin
            if (c == "\n")
                advance_line();
            advance_pos();
        end
        else if (is_digit(c))
        begin
            start_token(LX_NUMBER);
            advance_pos();
        end
        else if (is_alpha(c))
        begin
            start_token(LX_WORD);
            kw_live = narrow_keywords(8'hFF, 0, c);
            advance_pos();
        end
        else if (c == "/")
        begin
            start_token(LX_SLASH);
            advance_pos();
        end
        else if (c == "=")
        begin
            start_token(LX_EQUAL);
            advance_pos();
        end
        else if (op >= 0)
        begin
            queue_token(5'(op), lex_pos, 16'd1, lex_line);
            advance_pos();
        end
        else
        begin
            queue_token(KIND_ERROR, lex_pos, 16'd1, lex_line);
            lex_mode = LX_HALT;
        end
    endfunction

    function automatic void lex_reset();
        lex_mode  = LX_IDLE;
        lex_pos   = '0;
        lex_line  = 16'd1;
        tok_start = '0;
        tok_line  = 16'd1;
        kw_live   = '0;
    endfunction

    // one accepted transfer: update state, append its tokens to the expectation
    function automatic void lex_step(input logic [7:0] c, input logic eos);
        step_tokens.delete();
        if (eos)
        begin
            flush_token();
            queue_token(KIND_EOF, lex_pos, 16'd0, lex_line);
            lex_reset();
        end
        else
        begin
            case (lex_mode)
                LX_NUMBER:
                    if (is_digit(c))
                        advance_pos();
                    else
                    begin
                        flush_token();
                        scan_from_idle(c);
                    end
                LX_WORD:
                    if (is_alpha(c) || is_digit(c))
                    begin
                        // a word growing past the saturated position is no keyword
                        if (lex_pos == COUNT_MAX)
                            kw_live = '0;
                        else
                            kw_live = narrow_keywords(kw_live, int'(lex_pos - tok_start), c);
                        advance_pos();
                    end
                    else
                    begin
                        flush_token();
                        scan_from_idle(c);
                    end
                LX_SLASH:
                    if (c == "/")
                    begin
                        lex_mode = LX_COMMENT;
                        advance_pos();
                    end
                    else
                    begin
                        flush_token();
                        scan_from_idle(c);
                    end
                LX_EQUAL:
                    if (c == "=")
                    begin
                        advance_pos();
                        queue_token(KIND_EQEQ, tok_start, lex_pos - tok_start, tok_line);
                        lex_mode = LX_IDLE;
                    end
                    else
                    begin
                        flush_token();
                        scan_from_idle(c);
                    end
                LX_COMMENT:
                    if (c == "\n")
                    begin
                        lex_mode = LX_IDLE;
                        scan_from_idle(c);
                    end
                    else
                        advance_pos();
                LX_HALT: ;
                default:
                begin
                    lex_mode = LX_IDLE;
                    scan_from_idle(c);
                end
            endcase
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
        foreach (step_tokens[i])
            expected_tokens = {expected_tokens, step_tokens[i]};
    endfunction

    // ------------------------------------------------------------------------
    // source side
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [7:0] c, input logic eos);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push     <= 1'b1;
        src_item <= '{char_code: c, end_of_source: eos};
        do
            @(posedge clk);
        while (full);
        // bytes swallowed while halted do not count as traffic
        if (eos || lex_mode != LX_HALT)
            items_counted++;
        lex_step(c, eos);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic end_source();
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    function automatic logic [7:0] pick_char(input string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    function automatic logic [7:0] pick_unexpected();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (!is_unexpected(c));
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // token side
    // ------------------------------------------------------------------------
    always @(negedge clk)
        pop <= rst_n && !receiver_held && ($urandom_range(99) >= recv_stall_pct);

    // long receiver hold-off, counted here in clock cycles
    initial
    begin
        forever
        begin
            @(hold_go);
            receiver_held = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            receiver_held = 1'b0;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin : check_tokens
        token_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_tokens.size() == 0)
                report_mismatch($sformatf("token kind %0d start %0d with none expected",
                                          token.token_kind, token.token_start));
            else
            begin
                want = expected_tokens.pop_front();
                if (token.token_kind !== want.token_kind)
                    report_mismatch($sformatf("kind %0d, want %0d (start %0d)",
                                              token.token_kind, want.token_kind,
                                              want.token_start));
                if (token.token_start !== want.token_start)
                    report_mismatch($sformatf("start %0d, want %0d",
                                              token.token_start, want.token_start));
                if (token.token_length !== want.token_length)
                    report_mismatch($sformatf("length %0d, want %0d (start %0d)",
                                              token.token_length, want.token_length,
                                              want.token_start));
                if (token.token_line !== want.token_line)
                    report_mismatch($sformatf("line %0d, want %0d (start %0d)",
                                              token.token_line, want.token_line,
                                              want.token_start));
                if (token.last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run %0b, want %0b (start %0d)",
                                              token.last_of_run, want.last_of_run,
                                              want.token_start));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d tokens outstanding",
                     cycle_count, expected_tokens.size());
            $display("source_tokenizer verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_keywords();
        send_text("let print input if else while true false\n");
        send_text("lets pri iff elsewhere _tmp9 Let 007x ");
        end_source();
    endtask

    task automatic test_operators();
        send_text("+-*<(){};a=b==c = \t/ 8/2\r/");
        end_source();
    endtask

    task automatic test_comments();
        // lone slash, comment closed by newline, comment open at end
        send_text("x//skip + me\ny/ /z //tail");
        end_source();
    endtask

    task automatic test_unexpected_bytes();
        end_source();
        end_source();
        send_text("a1 #b+");
        end_source();
        send_item(8'h00, 1'b0);
        end_source();
        send_text("q");
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b0);
        end_source();
        send_text("=$");
        end_source();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        -> hold_go;
        repeat (16) send_text("(+);");
        end_source();
    endtask

    task automatic send_random_lexeme();
        int    pick;
        int    n;
        string word;
        logic  spaced;
        logic [7:0] c;
        pick   = $urandom_range(99);
        spaced = 1'b0;
        if (pick < 14)
        begin
            repeat ($urandom_range(5, 1)) send_item(pick_char(DIGITS), 1'b0);
            spaced = 1'b1;
        end
        else if (pick < 34)
        begin
            send_item($urandom_range(1) ? pick_char(KEY_LETTERS) : pick_char(LETTERS), 1'b0);
            repeat ($urandom_range(6))
                send_item($urandom_range(3) ? pick_char(KEY_LETTERS) : pick_char(DIGITS),
                          1'b0);
            spaced = 1'b1;
        end
        else if (pick < 49)
        begin
            word = kw_words[$urandom_range(7)];
            n = $urandom_range(99);
            if (n >= 80)
                word = word.substr(0, $urandom_range(word.len() - 2));
            send_text(word);
            if (n >= 60 && n < 80)
                send_item($urandom_range(1) ? pick_char(LETTERS) : pick_char(DIGITS), 1'b0);
            spaced = 1'b1;
        end
        else if (pick < 64)
            send_item(pick_char(OPS), 1'b0);
        else if (pick < 69)
            send_text("=");
        else if (pick < 74)
            send_text("==");
        else if (pick < 82)
            repeat ($urandom_range(3, 1)) send_item(pick_char(BLANKS), 1'b0);
        else if (pick < 87)
        begin
            send_text("//");
            repeat ($urandom_range(6))
            begin
                do
                    c = 8'($urandom_range(255));
                while (c == "\n");
                send_item(c, 1'b0);
            end
            if ($urandom_range(99) < 85)
                send_text("\n");
        end
        else if (pick < 90)
            send_text("/");
        else if (pick < 92)
        begin
            send_item(pick_unexpected(), 1'b0);
            repeat ($urandom_range(3)) send_item(8'($urandom_range(255)), 1'b0);
            end_source();
        end
        else if (pick < 96)
            send_text("\n");
        else
            end_source();
        if (spaced && $urandom_range(99) < 60)
            send_text(" ");
    endtask

    task automatic test_random_traffic(input int target, input int send_pct,
                                       input int recv_pct);
        int first;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        first = items_counted;
        while (items_counted - first < target)
            send_random_lexeme();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct  = 14;
        recv_stall_pct = 14;
        test_keywords();
        test_operators();
        test_comments();
        test_unexpected_bytes();
        test_backpressure();

        test_random_traffic(130, 0, 0);
        test_random_traffic(130, 52, 0);
        test_random_traffic(130, 0, 52);
        test_random_traffic(130, 14, 14);
        end_source();

        @(negedge clk);
        push <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("source_tokenizer verification clean");
        else
            $display("source_tokenizer verification failed");
        $finish;
    end

endmodule

// ----- source_tokenizer.f -----
rtl/core/stz_pkg.sv
rtl/core/stz_fifo.sv
rtl/core/stz_front.sv
rtl/core/stz_back.sv
rtl/core/stz_outq.sv
rtl/core/source_tokenizer.sv
tb/tb_top.sv
